FILE: hdl/amf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amf_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAX_WINDOW = 7;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int NBUF    = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_W   = $clog2(NBUF + 1);
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 8;
    localparam int WIN_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    // Request kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

FILE: hdl/adaptive_median_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Adaptive median filter over a 128 x 128 grayscale frame store.
//
// Requests are offered on start with kind, column, row and pixel_value and are
// taken at a rising edge where start is high and busy is low. A load request
// writes its pixel into the frame store in that same edge and leaves busy low,
// so loads may follow one another in every cycle. A query request raises busy
// and walks windows of side 3, 5 and 7 (up to max_window) around the clamped
// centre. The frame store is a synchronous memory with one read port, so the
// window is read one pixel per cycle; each pixel is insertion-sorted into a
// register row as it arrives, and the row then gives min, median and max.
// After its last read each window passes a drain state (read latency) and an
// evaluation state (the decision); busy stays high until the query ends.
// The result appears on filtered_value for exactly one cycle with result_valid
// high, in the first cycle in which busy is low again; the next request may be
// taken at the end of that cycle, and the receiver cannot stall. Configuration
// writes through cfg_write, cfg_index and cfg_data take effect at once; the
// user must make them only while busy is low; the block does not enforce this.
// Reset restores a 128 x 128 image and a largest window of 7; the frame store
// is not cleared, and a pixel must be loaded before any query reads it.
module adaptive_median_filter (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire                        kind,
    input  wire  [amf_pkg::COL_W-1:0]  column,
    input  wire  [amf_pkg::ROW_W-1:0]  row,
    input  wire  [amf_pkg::PIX_W-1:0]  pixel_value,
    input  wire                        cfg_write,
    input  wire  [1:0]                 cfg_index,
    input  wire  [amf_pkg::CFG_W-1:0]  cfg_data,
    output logic                       result_valid,
    output logic [amf_pkg::PIX_W-1:0]  filtered_value
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EVAL  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers.
    logic [amf_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [amf_pkg::WIN_W-1:0] window_reg;

    // Frame store.
    amf_pkg::pix_t mem [0:(1 << amf_pkg::ADDR_W)-1];
    amf_pkg::pix_t rdata_reg;

    // Query context.
    logic [amf_pkg::COL_W-1:0] cx_reg, cx_next, wm1_reg, wm1_next;
    logic [amf_pkg::ROW_W-1:0] cy_reg, cy_next, hm1_reg, hm1_next;
    logic [1:0]                half_reg, half_next, hmax_reg, hmax_next;
    logic signed [2:0]         dx_reg, dx_next, dy_reg, dy_next;
    logic                      rvalid_reg, rvalid_next, rcentre_reg, rcentre_next;
    amf_pkg::pix_t             centre_reg, centre_next;
    logic [amf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    amf_pkg::pix_t             sbuf_reg  [0:amf_pkg::NBUF-1];
    amf_pkg::pix_t             sbuf_next [0:amf_pkg::NBUF-1];
    logic                      res_valid_reg, res_valid_next;
    amf_pkg::pix_t             res_reg, res_next;

    logic accept;
    logic [amf_pkg::COL_W-1:0] clamp_w, xx;
    logic [amf_pkg::ROW_W-1:0] clamp_h, yy;
    logic [amf_pkg::WIN_W-1:0] smax;
    logic signed [8:0] xs, ys;
    logic [amf_pkg::ADDR_W-1:0] raddr;
    logic [amf_pkg::NBUF-1:0] gt;
    amf_pkg::pix_t zmin, zmax, zmed;
    logic signed [2:0] hs;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign result_valid   = res_valid_reg;
    assign filtered_value = res_reg;

    // Clamp the image size and window side into their legal ranges.
    always_comb
    begin
        if (width_reg == '0)
            clamp_w = '0;
        else if (width_reg > amf_pkg::CFG_W'(amf_pkg::MAX_WIDTH))
            clamp_w = amf_pkg::COL_W'(amf_pkg::MAX_WIDTH - 1);
        else
            clamp_w = amf_pkg::COL_W'(width_reg - 8'd1);
        if (height_reg == '0)
            clamp_h = '0;
        else if (height_reg > amf_pkg::CFG_W'(amf_pkg::MAX_HEIGHT))
            clamp_h = amf_pkg::ROW_W'(amf_pkg::MAX_HEIGHT - 1);
        else
            clamp_h = amf_pkg::ROW_W'(height_reg - 8'd1);
        smax = (window_reg < 3'd3) ? 3'd3 : window_reg;
        if (!smax[0])
            smax = smax - 3'd1;
    end

    // Window coordinates, replicated at the borders.
    always_comb
    begin
        xs = $signed({2'b00, cx_reg}) + 9'(dx_reg);
        ys = $signed({2'b00, cy_reg}) + 9'(dy_reg);
        if (xs < 0)
            xx = '0;
        else if (xs > $signed({2'b00, wm1_reg}))
            xx = wm1_reg;
        else
            xx = xs[amf_pkg::COL_W-1:0];
        if (ys < 0)
            yy = '0;
        else if (ys > $signed({2'b00, hm1_reg}))
            yy = hm1_reg;
        else
            yy = ys[amf_pkg::ROW_W-1:0];
        raddr = {yy, xx};
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == amf_pkg::KIND_LOAD)
            mem[{row, column}] <= pixel_value;
        if (state_reg == ST_READ)
            rdata_reg <= mem[raddr];
    end

    // Insertion of the arriving pixel into the sorted row: every entry decides
    // on its own whether it shifts up, takes the new pixel or stays.
    always_comb
    begin
        for (int k = 0; k < amf_pkg::NBUF; k++)
            gt[k] = (amf_pkg::CNT_W'(k) < cnt_reg) && (sbuf_reg[k] > rdata_reg);
        for (int k = 0; k < amf_pkg::NBUF; k++)
        begin
            if (k > 0 && gt[(k > 0) ? k - 1 : 0])
                sbuf_next[k] = sbuf_reg[(k > 0) ? k - 1 : 0];
            else if (gt[k] || amf_pkg::CNT_W'(k) == cnt_reg)
                sbuf_next[k] = rdata_reg;
            else
                sbuf_next[k] = sbuf_reg[k];
        end
    end

    // Statistics of the finished window.
    always_comb
    begin
        zmin = sbuf_reg[0];
        case (half_reg)
            2'd1:
            begin
                zmed = sbuf_reg[4];
                zmax = sbuf_reg[8];
            end
            2'd2:
            begin
                zmed = sbuf_reg[12];
                zmax = sbuf_reg[24];
            end
            default:
            begin
                zmed = sbuf_reg[24];
                zmax = sbuf_reg[48];
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        wm1_next       = wm1_reg;
        hm1_next       = hm1_reg;
        half_next      = half_reg;
        hmax_next      = hmax_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rvalid_next    = 1'b0;
        rcentre_next   = 1'b0;
        centre_next    = centre_reg;
        cnt_next       = cnt_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        hs             = $signed({1'b0, half_reg});

        if (rvalid_reg)
            cnt_next = cnt_reg + 1'b1;
        if (rcentre_reg)
            centre_next = rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == amf_pkg::KIND_QUERY)
                begin
                    cx_next   = (column > clamp_w) ? clamp_w : column;
                    cy_next   = (row > clamp_h) ? clamp_h : row;
                    wm1_next  = clamp_w;
                    hm1_next  = clamp_h;
                    hmax_next = smax[2:1];
                    half_next = 2'd1;
                    dx_next   = -3'sd1;
                    dy_next   = -3'sd1;
                    cnt_next  = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rvalid_next  = 1'b1;
                rcentre_next = (dx_reg == 3'sd0) && (dy_reg == 3'sd0);
                if (dx_reg == hs)
                begin
                    dx_next = -hs;
                    dy_next = dy_reg + 3'sd1;
                    if (dy_reg == hs)
                        state_next = ST_DRAIN;
                end
                else
                    dx_next = dx_reg + 3'sd1;
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL;
            end
            default:
            begin
                if (zmin < zmed && zmed < zmax)
                begin
                    res_next = (zmin < centre_reg && centre_reg < zmax) ? centre_reg : zmed;
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (half_reg == hmax_reg)
                begin
                    res_next = zmed;
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Grow the window and sort it afresh.
                    half_next = half_reg + 2'd1;
                    dx_next   = -(hs + 3'sd1);
                    dy_next   = -(hs + 3'sd1);
                    cnt_next  = '0;
                    state_next = ST_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= amf_pkg::CFG_W'(amf_pkg::MAX_WIDTH);
            height_reg    <= amf_pkg::CFG_W'(amf_pkg::MAX_HEIGHT);
            window_reg    <= amf_pkg::WIN_W'(amf_pkg::MAX_WINDOW);
            rvalid_reg    <= 1'b0;
            rcentre_reg   <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rvalid_reg    <= rvalid_next;
            rcentre_reg   <= rcentre_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    amf_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    amf_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    amf_pkg::REG_WINDOW: window_reg <= cfg_data[amf_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        wm1_reg    <= wm1_next;
        hm1_reg    <= hm1_next;
        half_reg   <= half_next;
        hmax_reg   <= hmax_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        centre_reg <= centre_next;
        res_reg    <= res_next;
        if (rvalid_reg)
            sbuf_reg <= sbuf_next;
    end

`ifndef SYNTHESIS
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while a query is still running");
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == amf_pkg::KIND_LOAD) |=> !result_valid)
        else $error("load request produced a result");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= amf_pkg::CNT_W'(amf_pkg::NBUF))
        else $error("sort row overflow");
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == amf_pkg::KIND_QUERY) |=> busy)
        else $error("query request did not raise busy");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STORE_DEPTH = amf_pkg::MAX_WIDTH * amf_pkg::MAX_HEIGHT;

    // Value shapes used for pixel content: full range, impulse noise and a
    // narrow band, so that windows both qualify and fail to qualify.
    typedef enum int { SHAPE_ANY, SHAPE_IMPULSE, SHAPE_FLAT } shape_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       req_kind = amf_pkg::KIND_LOAD;
    logic [amf_pkg::COL_W-1:0]  req_col = '0;
    logic [amf_pkg::ROW_W-1:0]  req_row = '0;
    logic [amf_pkg::PIX_W-1:0]  req_pixel = '0;
    logic                       cfg_write = 1'b0;
    logic [1:0]                 cfg_index = amf_pkg::REG_WIDTH;
    logic [amf_pkg::CFG_W-1:0]  cfg_data = '0;
    wire                        busy;
    wire                        result_valid;
    wire  [amf_pkg::PIX_W-1:0]  filtered_value;

    // Mirror of the block: frame store, which entries have been written, and
    // the raw register values as last written.
    amf_pkg::pix_t              pixel_mem [0:STORE_DEPTH-1];
    bit                         pixel_known [0:STORE_DEPTH-1];
    logic [amf_pkg::CFG_W-1:0]  width_reg;
    logic [amf_pkg::CFG_W-1:0]  height_reg;
    logic [amf_pkg::WIN_W-1:0]  window_reg;

    amf_pkg::pix_t  filtered_due[$];
    int    failures = 0;
    int    requests_sent = 0;
    bit    quiet = 1'b0;
    shape_t shape = SHAPE_ANY;

    always #1 clk = ~clk;

    adaptive_median_filter i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (req_kind),
        .column         (req_col),
        .row            (req_row),
        .pixel_value    (req_pixel),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .filtered_value (filtered_value)
    );

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int eff_width();
        return clamp(int'(width_reg), 1, amf_pkg::MAX_WIDTH);
    endfunction

    function automatic int eff_height();
        return clamp(int'(height_reg), 1, amf_pkg::MAX_HEIGHT);
    endfunction

    // Largest window side actually tried: clamped to 3..MAX_WINDOW and odd.
    function automatic int eff_side();
        int s;
        s = clamp(int'(window_reg), 3, amf_pkg::MAX_WINDOW);
        if (s % 2 == 0) s = s - 1;
        return s;
    endfunction

    // Adaptive median of the pixel at (cx, cy), grown window by window.
    function automatic amf_pkg::pix_t adaptive_median(input int cx, input int cy);
        amf_pkg::pix_t sorted [0:amf_pkg::NBUF-1];
        amf_pkg::pix_t centre, v, lo, hi, mid;
        int w, h, smax, half, n, k, yy, xx;
        w = eff_width();
        h = eff_height();
        smax = eff_side();
        cx = clamp(cx, 0, w - 1);
        cy = clamp(cy, 0, h - 1);
        centre = pixel_mem[cy * amf_pkg::MAX_WIDTH + cx];
        mid = centre;
        for (int s = 3; s <= smax; s += 2) begin
            half = s / 2;
            n = 0;
            for (int i = -half; i <= half; i++) begin
                yy = clamp(cy + i, 0, h - 1);
                for (int j = -half; j <= half; j++) begin
                    xx = clamp(cx + j, 0, w - 1);
                    v = pixel_mem[yy * amf_pkg::MAX_WIDTH + xx];
                    k = n;
                    while (k > 0 && sorted[k-1] > v) begin
                        sorted[k] = sorted[k-1];
                        k--;
                    end
                    sorted[k] = v;
                    n++;
                end
            end
            lo = sorted[0];
            hi = sorted[n-1];
            mid = sorted[n/2];
            if (lo < mid && mid < hi) begin
                if (lo < centre && centre < hi) return centre;
                return mid;
            end
        end
        return mid;
    endfunction

    function automatic amf_pkg::pix_t pick_pixel();
        case (shape)
            SHAPE_IMPULSE: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            SHAPE_FLAT:    return amf_pkg::pix_t'($urandom_range(100, 103));
            default:       return amf_pkg::pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one request and waits until the block takes it. start is left high
    // so that back-to-back requests need no extra assignment; park() lowers it.
    task automatic send_request(input logic k, input int col, input int rw,
                                input amf_pkg::pix_t value);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start     <= 1'b1;
        req_kind  <= k;
        req_col   <= amf_pkg::COL_W'(col);
        req_row   <= amf_pkg::ROW_W'(rw);
        req_pixel <= value;
        @(posedge clk);
        while (busy) @(posedge clk);
        requests_sent++;
        if (k == amf_pkg::KIND_LOAD)
        begin
            pixel_mem[rw * amf_pkg::MAX_WIDTH + col] = value;
            pixel_known[rw * amf_pkg::MAX_WIDTH + col] = 1'b1;
        end
        else
        begin
            filtered_due = {filtered_due, adaptive_median(col, rw)};
        end
    endtask

    // Loads every pixel that a query at (cx, cy) could read and that has
    // never been written, so no query ever touches an undefined entry.
    task automatic query_safely(input int cx, input int cy);
        int w, h, half, x0, y0, a;
        w = eff_width();
        h = eff_height();
        half = eff_side() / 2;
        x0 = clamp(cx, 0, w - 1);
        y0 = clamp(cy, 0, h - 1);
        for (int i = -half; i <= half; i++)
        begin
            for (int j = -half; j <= half; j++)
            begin
                a = clamp(y0 + i, 0, h - 1) * amf_pkg::MAX_WIDTH
                    + clamp(x0 + j, 0, w - 1);
                if (!pixel_known[a])
                    send_request(amf_pkg::KIND_LOAD, a % amf_pkg::MAX_WIDTH,
                                 a / amf_pkg::MAX_WIDTH, pick_pixel());
            end
        end
        send_request(amf_pkg::KIND_QUERY, cx, cy, pick_pixel());
    endtask

    // Lowers start and waits until every expected result is in and the block
    // is idle, plus a few cycles, so that registers may be written safely.
    task automatic park();
        start <= 1'b0;
        @(posedge clk);
        while (filtered_due.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input int value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= amf_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            amf_pkg::REG_WIDTH:  width_reg  = amf_pkg::CFG_W'(value);
            amf_pkg::REG_HEIGHT: height_reg = amf_pkg::CFG_W'(value);
            amf_pkg::REG_WINDOW: window_reg = amf_pkg::WIN_W'(value);
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int h, input int s);
        park();
        write_reg(amf_pkg::REG_WIDTH, w);
        write_reg(amf_pkg::REG_HEIGHT, h);
        write_reg(amf_pkg::REG_WINDOW, s);
    endtask

    // Corners and extremes of the full 128 x 128 image at the reset settings,
    // with impulse noise and flat areas around them.
    task automatic test_corners();
        send_request(amf_pkg::KIND_LOAD, 0, 0, 8'd0);
        send_request(amf_pkg::KIND_LOAD, 127, 127, 8'd255);
        send_request(amf_pkg::KIND_LOAD, 1, 0, 8'd255);
        query_safely(0, 0);
        query_safely(127, 127);
        shape = SHAPE_IMPULSE;
        query_safely(127, 0);
        shape = SHAPE_FLAT;
        query_safely(0, 127);
        shape = SHAPE_ANY;
        query_safely(64, 85);
    endtask

    // Out-of-range register values, an unknown index and queries outside a
    // shrunken image, which must be clamped back inside it.
    task automatic test_register_edges();
        configure(0, 0, 0);
        query_safely(127, 127);
        configure(200, 1, 2);
        query_safely(5, 90);
        configure(1, 255, 4);
        query_safely(100, 3);
        configure(3, 3, 6);
        write_reg(REG_UNUSED, 8'hff);
        query_safely(1, 1);
        query_safely(126, 126);
        configure(128, 128, 8);     // only the low three bits reach the register
        query_safely(40, 41);
        configure(10, 12, 7);
        query_safely(9, 11);
    endtask

    // Random phases with a new setting each time. Images are kept small so
    // that queries quickly find their windows loaded; query coordinates still
    // span the whole port range and are clamped by the block.
    task automatic test_random();
        int phase_end, w, h;
        while (requests_sent < 1450)
        begin
            case ($urandom_range(0, 4))
                0:       begin w = 1;   h = $urandom_range(1, 4); end
                1:       begin w = 128; h = 128; end
                default: begin w = $urandom_range(1, 14); h = $urandom_range(1, 14); end
            endcase
            configure(w, h, $urandom_range(0, 7));
            shape = shape_t'($urandom_range(0, 2));
            quiet = (requests_sent > 1200);
            phase_end = requests_sent + 150;
            while (requests_sent < phase_end && requests_sent < 1450)
            begin
                if ($urandom_range(0, 9) < 4)
                    send_request(amf_pkg::KIND_LOAD, $urandom_range(0, eff_width() + 2 > 127 ?
                                 127 : eff_width() + 2), $urandom_range(0, 127),
                                 pick_pixel());
                else if ($urandom_range(0, 3) == 0)
                    query_safely($urandom_range(0, 127), $urandom_range(0, 127));
                else
                    query_safely($urandom_range(0, eff_width() - 1),
                                 $urandom_range(0, eff_height() - 1));
            end
        end
    endtask

    // Every strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (filtered_due.size() == 0)
            begin
                $error("filtered_value: nothing expected, actual %0d", filtered_value);
                failures++;
            end
            else
            begin
                amf_pkg::pix_t want;
                want = filtered_due.pop_front();
                if (filtered_value !== want)
                begin
                    $error("filtered_value: expected %0d, actual %0d", want, filtered_value);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        width_reg  = 8'd128;
        height_reg = 8'd128;
        window_reg = 3'd7;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_register_edges();
        test_random();
        park();
        repeat (100) @(posedge clk);
        if (failures == 0 && filtered_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/amf_pkg.sv
hdl/adaptive_median_filter.sv
bench/tb.sv
